// ===== rtl/core/three_zone_window_waveshaper_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the waveshaper top level.
// ----------------------------------------------------------------------------
`ifndef THREE_ZONE_WINDOW_WAVESHAPER_ASSERT_SVH
`define THREE_ZONE_WINDOW_WAVESHAPER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALL(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/tzw_pkg.sv =====
// ----------------------------------------------------------------------------
// tzw_pkg
// Types, widths and register codes of the three-zone window waveshaper.
// ----------------------------------------------------------------------------
package tzw_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int N_STAGES  = 7;
    localparam int N_CTL     = 7;
    localparam int CTL_IDX_W = $clog2(N_CTL);
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 32;
    localparam int MODE_W    = 3;

    localparam int CV_W   = 16;
    localparam int PROD_W = 32;
    localparam int CTL_W  = 19;
    localparam int X_W    = 20;
    localparam int EX_W   = 21;
    localparam int PM_W   = 39;
    localparam int PZ_W   = 40;
    localparam int YM_W   = 29;
    localparam int YZ_W   = 30;
    localparam int Y_W    = 31;
    localparam int SUM_W  = 33;

    localparam int AMT_SHIFT  = 14;
    localparam int GAIN_SHIFT = 10;
    localparam int CLIP_LIMIT = 5120;

    localparam int CTL_IN_OFF   = 0;
    localparam int CTL_OUT_OFF  = 1;
    localparam int CTL_HI_GAIN  = 2;
    localparam int CTL_TH_A     = 3;
    localparam int CTL_MID_GAIN = 4;
    localparam int CTL_TH_B     = 5;
    localparam int CTL_LO_GAIN  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = CFG_IDX_W'(N_CTL);
    localparam logic [MODE_W-1:0]    MODE_RESET   = 3'd5;
    localparam int                   HARD_CLIP_BIT = 2;

    typedef enum logic [1:0] {
        CLAMP_OFF  = 2'd0,
        CLAMP_PRE  = 2'd1,
        CLAMP_POST = 2'd2,
        CLAMP_BOTH = 2'd3
    } t_clamp;

    typedef logic [N_CTL-1:0][CV_W-1:0] t_cv_vec;

    typedef struct packed {
        logic [N_CTL-1:0][CV_W-1:0] base;
        logic [N_CTL-1:0][CV_W-1:0] amt;
        t_clamp                     clamp;
        logic                       hard_clip;
    } t_ctl_regs;

    typedef struct packed {
        logic [N_STAGES-1:0] load;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [X_W-1:0]   x;
        logic signed [CTL_W-1:0] hi_th;
        logic signed [CTL_W-1:0] lo_th;
        logic signed [CTL_W-1:0] mid_gain;
        logic signed [CTL_W-1:0] hi_gain;
        logic signed [CTL_W-1:0] lo_gain;
        logic signed [CTL_W-1:0] out_off;
    } t_ctl_out;

    typedef struct packed {
        logic signed [Y_W-1:0]   y;
        logic signed [CTL_W-1:0] out_off;
    } t_shape_out;

endpackage

// ===== rtl/core/tzw_regs.sv =====
// ----------------------------------------------------------------------------
// tzw_regs
// Configuration register file: seven control words and the mode bits.
// ----------------------------------------------------------------------------
module tzw_regs
    import tzw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_ctl_regs            o_regs
);

    logic [N_CTL-1:0][CFG_W-1:0] r_ctl;
    logic [MODE_W-1:0]           r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_mode <= MODE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index < CFG_IDX_W'(N_CTL)) begin
                r_ctl[i_cfg_index[CTL_IDX_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N_CTL; k++) begin
            o_regs.base[k] = r_ctl[k][CFG_W-1:CV_W];
            o_regs.amt[k]  = r_ctl[k][CV_W-1:0];
        end
        o_regs.clamp     = t_clamp'(r_mode[1:0]);
        o_regs.hard_clip = r_mode[HARD_CLIP_BIT];
    end

endmodule

// ===== rtl/core/tzw_ctl.sv =====
// ----------------------------------------------------------------------------
// tzw_ctl
// Control formation: CV times amount, base added, thresholds sorted.
// ----------------------------------------------------------------------------
module tzw_ctl
    import tzw_pkg::*;
(
    input  logic                   i_clk,
    input  t_pipe_ctl              i_pipe,
    input  logic signed [CV_W-1:0] i_wave,
    input  t_cv_vec                i_cv,
    input  t_ctl_regs              i_regs,
    output t_ctl_out               o_ctl
);

    logic signed [PROD_W-1:0] r_prod [N_CTL];
    logic signed [CV_W-1:0]   r_wave;
    t_ctl_out                 r_q;
    t_ctl_out                 n_q;
    logic signed [CTL_W-1:0]  w_ctl [N_CTL];

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[0]) begin
            for (int k = 0; k < N_CTL; k++) begin
                r_prod[k] <= $signed(i_cv[k]) * $signed(i_regs.amt[k]);
            end
            r_wave <= i_wave;
        end
    end

    always_comb begin
        for (int k = 0; k < N_CTL; k++) begin
            w_ctl[k] = CTL_W'($signed(i_regs.base[k])) + CTL_W'(r_prod[k] >>> AMT_SHIFT);
        end
        n_q.x        = X_W'(r_wave) + X_W'(w_ctl[CTL_IN_OFF]);
        n_q.hi_th    = (w_ctl[CTL_TH_A] > w_ctl[CTL_TH_B]) ? w_ctl[CTL_TH_A] : w_ctl[CTL_TH_B];
        n_q.lo_th    = (w_ctl[CTL_TH_A] > w_ctl[CTL_TH_B]) ? w_ctl[CTL_TH_B] : w_ctl[CTL_TH_A];
        n_q.mid_gain = w_ctl[CTL_MID_GAIN];
        n_q.hi_gain  = w_ctl[CTL_HI_GAIN];
        n_q.lo_gain  = w_ctl[CTL_LO_GAIN];
        n_q.out_off  = w_ctl[CTL_OUT_OFF];
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[1]) begin
            r_q <= n_q;
        end
    end

    assign o_ctl = r_q;

endmodule

// ===== rtl/core/tzw_shape.sv =====
// ----------------------------------------------------------------------------
// tzw_shape
// Zone shaping: window clamp, middle gain and high or low zone excess gain.
// ----------------------------------------------------------------------------
module tzw_shape
    import tzw_pkg::*;
(
    input  logic       i_clk,
    input  t_pipe_ctl  i_pipe,
    input  t_ctl_out   i_ctl,
    input  t_clamp     i_clamp,
    output t_shape_out o_shape
);

    logic signed [X_W-1:0]   w_hi_x;
    logic signed [X_W-1:0]   w_lo_x;
    logic                    w_above;
    logic                    w_below;
    logic                    w_pre;
    logic                    w_post;

    logic signed [X_W-1:0]   r3_xm;
    logic signed [EX_W-1:0]  r3_ex;
    logic signed [CTL_W-1:0] r3_zg;
    logic signed [CTL_W-1:0] r3_mid_g;
    logic signed [CTL_W-1:0] r3_hi;
    logic signed [CTL_W-1:0] r3_lo;
    logic signed [CTL_W-1:0] r3_off;

    logic signed [PM_W-1:0]  r4_pm;
    logic signed [PZ_W-1:0]  r4_pz;
    logic signed [CTL_W-1:0] r4_hi;
    logic signed [CTL_W-1:0] r4_lo;
    logic signed [CTL_W-1:0] r4_off;

    logic signed [YM_W-1:0]  w_ym;
    logic signed [YM_W-1:0]  w_ym_hi;
    logic signed [YM_W-1:0]  w_ym_lo;
    logic signed [YM_W-1:0]  w_ymc;
    logic signed [YZ_W-1:0]  w_yz;

    t_shape_out              r5_q;

    assign w_pre  = (i_clamp == CLAMP_PRE)  || (i_clamp == CLAMP_BOTH);
    assign w_post = (i_clamp == CLAMP_POST) || (i_clamp == CLAMP_BOTH);

    assign w_hi_x  = X_W'(i_ctl.hi_th);
    assign w_lo_x  = X_W'(i_ctl.lo_th);
    assign w_above = i_ctl.x > w_hi_x;
    assign w_below = i_ctl.x < w_lo_x;

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[2]) begin
            if (w_pre && w_below) begin
                r3_xm <= w_lo_x;
            end else if (w_pre && w_above) begin
                r3_xm <= w_hi_x;
            end else begin
                r3_xm <= i_ctl.x;
            end
            if (w_above) begin
                r3_ex <= EX_W'(i_ctl.x) - EX_W'(i_ctl.hi_th);
                r3_zg <= i_ctl.hi_gain;
            end else if (w_below) begin
                r3_ex <= EX_W'(i_ctl.x) - EX_W'(i_ctl.lo_th);
                r3_zg <= i_ctl.lo_gain;
            end else begin
                r3_ex <= '0;
                r3_zg <= '0;
            end
            r3_mid_g <= i_ctl.mid_gain;
            r3_hi    <= i_ctl.hi_th;
            r3_lo    <= i_ctl.lo_th;
            r3_off   <= i_ctl.out_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[3]) begin
            r4_pm  <= PM_W'(r3_xm) * PM_W'(r3_mid_g);
            r4_pz  <= PZ_W'(r3_ex) * PZ_W'(r3_zg);
            r4_hi  <= r3_hi;
            r4_lo  <= r3_lo;
            r4_off <= r3_off;
        end
    end

    always_comb begin
        w_ym    = YM_W'(r4_pm >>> GAIN_SHIFT);
        w_yz    = YZ_W'(r4_pz >>> GAIN_SHIFT);
        w_ym_hi = YM_W'(r4_hi);
        w_ym_lo = YM_W'(r4_lo);
        if (w_post && (w_ym < w_ym_lo)) begin
            w_ymc = w_ym_lo;
        end else if (w_post && (w_ym > w_ym_hi)) begin
            w_ymc = w_ym_hi;
        end else begin
            w_ymc = w_ym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[4]) begin
            r5_q.y       <= Y_W'(w_ymc) + Y_W'(w_yz);
            r5_q.out_off <= r4_off;
        end
    end

    assign o_shape = r5_q;

endmodule

// ===== rtl/core/tzw_out.sv =====
// ----------------------------------------------------------------------------
// tzw_out
// Output stage: optional hard clip, output offset and saturation.
// ----------------------------------------------------------------------------
module tzw_out
    import tzw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  t_pipe_ctl              i_pipe,
    input  t_shape_out             i_shape,
    input  logic                   i_hard_clip,
    output logic signed [CV_W-1:0] o_wave
);

    localparam logic signed [Y_W-1:0]   CLIP_HI = Y_W'(CLIP_LIMIT);
    localparam logic signed [Y_W-1:0]   CLIP_LO = -CLIP_HI;
    localparam logic signed [SUM_W-1:0] SMAX =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;

    logic signed [Y_W-1:0]   r6_y;
    logic signed [CTL_W-1:0] r6_off;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_sat;
    logic signed [CV_W-1:0]  r7_wave;

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[5]) begin
            if (i_hard_clip && (i_shape.y > CLIP_HI)) begin
                r6_y <= CLIP_HI;
            end else if (i_hard_clip && (i_shape.y < CLIP_LO)) begin
                r6_y <= CLIP_LO;
            end else begin
                r6_y <= i_shape.y;
            end
            r6_off <= i_shape.out_off;
        end
    end

    always_comb begin
        w_sum = SUM_W'(r6_y) + SUM_W'(r6_off);
        if (w_sum > SMAX) begin
            w_sat = SMAX;
        end else if (w_sum < SMIN) begin
            w_sat = SMIN;
        end else begin
            w_sat = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[6]) begin
            r7_wave <= w_sat[CV_W-1:0];
        end
    end

    assign o_wave = r7_wave;

endmodule

// ===== rtl/core/three_zone_window_waveshaper.sv =====
// ----------------------------------------------------------------------------
// three_zone_window_waveshaper
// Seven-stage pipelined three-zone window waveshaper with CV-modulated
// controls.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// in        sink       i_in_valid / o_in_ready      i_wave_in and seven CVs
// out       source     o_out_valid / i_out_ready    o_wave_out
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One sample per cycle while the output is not stalled; o_out_valid rises once
// the sample has passed the seven register stages (CV products, controls,
// window, gain multipliers, zone sum, clip, offset and saturation).
// Each stage loads when it is empty or the stage after it loads, so a stall
// holds every transaction in place and bubbles close up.
// Synchronous reset empties the pipeline and restores the control words.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
`include "three_zone_window_waveshaper_assert.svh"

module three_zone_window_waveshaper
    import tzw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [CV_W-1:0] i_wave_in,
    input  logic signed [CV_W-1:0] i_input_offset_cv,
    input  logic signed [CV_W-1:0] i_output_offset_cv,
    input  logic signed [CV_W-1:0] i_high_gain_cv,
    input  logic signed [CV_W-1:0] i_high_threshold_cv,
    input  logic signed [CV_W-1:0] i_middle_gain_cv,
    input  logic signed [CV_W-1:0] i_low_threshold_cv,
    input  logic signed [CV_W-1:0] i_low_gain_cv,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [CV_W-1:0] o_wave_out,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_ctl_regs           w_regs;
    t_cv_vec             w_cv;
    t_pipe_ctl           w_pipe;
    t_ctl_out            w_ctl;
    t_shape_out          w_shape;
    logic [N_STAGES-1:0] r_vld;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cv[CTL_IN_OFF]   = i_input_offset_cv;
        w_cv[CTL_OUT_OFF]  = i_output_offset_cv;
        w_cv[CTL_HI_GAIN]  = i_high_gain_cv;
        w_cv[CTL_TH_A]     = i_high_threshold_cv;
        w_cv[CTL_MID_GAIN] = i_middle_gain_cv;
        w_cv[CTL_TH_B]     = i_low_threshold_cv;
        w_cv[CTL_LO_GAIN]  = i_low_gain_cv;
    end

    always_comb begin
        w_pipe.load[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_pipe.load[k] = !r_vld[k] || w_pipe.load[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_pipe.load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_pipe.load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_pipe.load[0];
    assign o_out_valid = r_vld[N_STAGES-1];

    tzw_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (w_regs)
    );

    tzw_ctl u_ctl (
        .i_clk  (i_clk),
        .i_pipe (w_pipe),
        .i_wave (i_wave_in),
        .i_cv   (w_cv),
        .i_regs (w_regs),
        .o_ctl  (w_ctl)
    );

    tzw_shape u_shape (
        .i_clk   (i_clk),
        .i_pipe  (w_pipe),
        .i_ctl   (w_ctl),
        .i_clamp (w_regs.clamp),
        .o_shape (w_shape)
    );

    tzw_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_pipe      (w_pipe),
        .i_shape     (w_shape),
        .i_hard_clip (w_regs.hard_clip),
        .o_wave      (o_wave_out)
    );

    `ASSERT_RST(a_ready_when_drained, i_clk, i_rst_n, i_out_ready |-> o_in_ready, "input stalled")
    `ASSERT_RST(a_ready_when_empty, i_clk, i_rst_n, (r_vld == '0) |-> o_in_ready, "empty not ready")
    `ASSERT_RST(a_stage_holds, i_clk, i_rst_n, (r_vld[1] && !w_pipe.load[1]) |=> r_vld[1], "drop")
    `ASSERT_ALL(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

// ===== bench/three_zone_window_waveshaper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_zone_window_waveshaper_tb
// Self-checking bench for the three-zone window waveshaper. Input samples
// come from a queue and are driven with random gaps. The output side stalls
// at random and holds off once for a long stretch. Each accepted sample is
// shaped by a local model under the current control words, and every output
// transaction is compared with the oldest expected sample. Settings change
// between phases while the pipeline is empty: directed clamp modes, the hard
// clip, equal and swapped thresholds, spare register indexes, then random
// phases.
// ----------------------------------------------------------------------------
module three_zone_window_waveshaper_tb;
    import tzw_pkg::*;

    localparam int SMPL_BITS       = SAMPLE_BITS_DEF;
    localparam int MAX_GAP         = 16;
    localparam int HOLD_CYCLES     = 120;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RND_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int PRESSURE_PHASE  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    typedef struct packed {
        logic signed [CV_W-1:0] wave;
        logic signed [CV_W-1:0] in_off_cv;
        logic signed [CV_W-1:0] out_off_cv;
        logic signed [CV_W-1:0] hi_gain_cv;
        logic signed [CV_W-1:0] th_a_cv;
        logic signed [CV_W-1:0] mid_gain_cv;
        logic signed [CV_W-1:0] th_b_cv;
        logic signed [CV_W-1:0] lo_gain_cv;
    } t_shaper_in;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   o_in_ready;
    t_shaper_in             drv_item = '0;
    logic                   o_out_valid;
    logic                   out_ready = 1'b0;
    logic signed [CV_W-1:0] o_wave_out;
    logic                   cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    t_shaper_in             sample_q[$];
    logic signed [CV_W-1:0] shaped_wave_q[$];

    logic [CFG_W-1:0]  ctl_word[N_CTL] = '{default: '0};
    logic [MODE_W-1:0] mode_word = MODE_RESET;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   quiet_cycles = 0;
    int   mismatches = 0;

    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    bit   hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   tx_wait = 0;
    int   rx_wait = 0;
    logic tx_next;
    logic rx_next;

    three_zone_window_waveshaper #(
        .SAMPLE_BITS(SMPL_BITS)
    ) DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_wave_in           (drv_item.wave),
        .i_input_offset_cv   (drv_item.in_off_cv),
        .i_output_offset_cv  (drv_item.out_off_cv),
        .i_high_gain_cv      (drv_item.hi_gain_cv),
        .i_high_threshold_cv (drv_item.th_a_cv),
        .i_middle_gain_cv    (drv_item.mid_gain_cv),
        .i_low_threshold_cv  (drv_item.th_b_cv),
        .i_low_gain_cv       (drv_item.lo_gain_cv),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_wave_out          (o_wave_out),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic longint ctl_level(int idx, logic signed [CV_W-1:0] cv);
        logic signed [CV_W-1:0] base;
        logic signed [CV_W-1:0] amt;
        base = ctl_word[idx][CFG_W-1:CV_W];
        amt  = ctl_word[idx][CV_W-1:0];
        return longint'(base) + ((longint'(cv) * longint'(amt)) >>> AMT_SHIFT);
    endfunction

    function automatic logic signed [CV_W-1:0] shape_sample(t_shaper_in s);
        longint in_off, out_off, hi_gain, th_a, mid_gain, th_b, lo_gain;
        longint hi_th, lo_th, x, y, smax;
        in_off   = ctl_level(CTL_IN_OFF, s.in_off_cv);
        out_off  = ctl_level(CTL_OUT_OFF, s.out_off_cv);
        hi_gain  = ctl_level(CTL_HI_GAIN, s.hi_gain_cv);
        th_a     = ctl_level(CTL_TH_A, s.th_a_cv);
        mid_gain = ctl_level(CTL_MID_GAIN, s.mid_gain_cv);
        th_b     = ctl_level(CTL_TH_B, s.th_b_cv);
        lo_gain  = ctl_level(CTL_LO_GAIN, s.lo_gain_cv);
        hi_th = (th_a > th_b) ? th_a : th_b;
        lo_th = (th_a > th_b) ? th_b : th_a;
        x = longint'(s.wave) + in_off;
        case (t_clamp'(mode_word[1:0]))
            CLAMP_OFF: begin
                y = (x * mid_gain) >>> GAIN_SHIFT;
            end
            CLAMP_PRE: begin
                y = (clamp_to(x, lo_th, hi_th) * mid_gain) >>> GAIN_SHIFT;
            end
            CLAMP_POST: begin
                y = clamp_to((x * mid_gain) >>> GAIN_SHIFT, lo_th, hi_th);
            end
            default: begin
                y = clamp_to((clamp_to(x, lo_th, hi_th) * mid_gain) >>> GAIN_SHIFT,
                             lo_th, hi_th);
            end
        endcase
        if (x > hi_th) begin
            y += ((x - hi_th) * hi_gain) >>> GAIN_SHIFT;
        end else if (x < lo_th) begin
            y += ((x - lo_th) * lo_gain) >>> GAIN_SHIFT;
        end
        if (mode_word[HARD_CLIP_BIT]) begin
            y = clamp_to(y, -CLIP_LIMIT, CLIP_LIMIT);
        end
        smax = (longint'(1) << (SMPL_BITS - 1)) - 1;
        y = clamp_to(y + out_off, -smax - 1, smax);
        return y[CV_W-1:0];
    endfunction

    function automatic int pick_gap(bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic logic [CV_W-1:0] pick_cv();
        case ($urandom_range(0, 9))
            0: begin
                return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            1, 2: begin
                return CV_W'($urandom);
            end
            default: begin
                return CV_W'($urandom_range(0, 12288) - 6144);
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_ctl_word();
        logic [CV_W-1:0] base;
        logic [CV_W-1:0] amt;
        case ($urandom_range(0, 7))
            0: begin
                base = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            1: begin
                base = CV_W'($urandom);
            end
            default: begin
                base = CV_W'($urandom_range(0, 8192) - 4096);
            end
        endcase
        case ($urandom_range(0, 7))
            0: begin
                amt = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            1: begin
                amt = '0;
            end
            2: begin
                amt = CV_W'($urandom);
            end
            default: begin
                amt = CV_W'($urandom_range(0, 16384) - 8192);
            end
        endcase
        return {base, amt};
    endfunction

    // Record transactions, shape accepted samples and check the output.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_fire      <= 1'b0;
            out_fire     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_fire  <= in_valid && o_in_ready;
            out_fire <= o_out_valid && out_ready;
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_index < N_CTL) begin
                    ctl_word[cfg_index[CTL_IDX_W-1:0]] = cfg_data;
                end else if (cfg_index == CFG_IDX_MODE) begin
                    mode_word = cfg_data[MODE_W-1:0];
                end
            end
            if (in_valid && o_in_ready) begin
                shaped_wave_q = {shaped_wave_q, shape_sample(drv_item)};
            end
            if (o_out_valid && out_ready) begin
                if (shaped_wave_q.size() == 0) begin
                    $display("%0t: unexpected wave_out %0d", $time, o_wave_out);
                    mismatches++;
                end else if (o_wave_out !== shaped_wave_q[0]) begin
                    $display("%0t: wave_out mismatch, expected %0d, actual %0d",
                             $time, shaped_wave_q[0], o_wave_out);
                    mismatches++;
                    void'(shaped_wave_q.pop_front());
                end else begin
                    void'(shaped_wave_q.pop_front());
                end
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                    || (cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Input driver: advance to the next sample after each transaction.
    always @(negedge clk) begin
        tx_next = in_valid;
        if (rst_n) begin
            if (in_valid && in_fire) begin
                tx_next = 1'b0;
                tx_wait = pick_gap(tx_idle_on);
            end
            if (!tx_next) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                end else if (sample_q.size() != 0) begin
                    drv_item <= sample_q.pop_front();
                    tx_next = 1'b1;
                end
            end
        end
        in_valid <= tx_next;
    end

    // Output side: may stall after each transaction, hold off once for a long stretch.
    always @(negedge clk) begin
        rx_next = out_ready;
        if (rst_n) begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                rx_wait    = HOLD_CYCLES;
                rx_next    = 1'b0;
            end else if (out_ready && out_fire) begin
                rx_wait = pick_gap(rx_idle_on);
                rx_next = (rx_wait == 0);
            end else if (!out_ready) begin
                if (rx_wait != 0) begin
                    rx_wait--;
                end
                rx_next = (rx_wait == 0);
            end
        end
        out_ready <= rx_next;
    end

    task automatic wait_idle();
        do @(posedge clk);
        while (sample_q.size() != 0 || in_valid || shaped_wave_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!o_cfg_ready);
    endtask

    task automatic end_cfg();
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_sample(input logic [CV_W-1:0] wave, input logic [CV_W-1:0] cv);
        t_shaper_in s;
        s = {wave, {(N_CTL){cv}}};
        sample_q = {sample_q, s};
    endtask

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_shaper_in s;
        int         ph;
        int         i;
        int         m;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset control words.
        push_sample(16'h7FFF, 16'h0400);

        for (m = 0; m < 8; m++) begin
            wait_idle();
            if (m == 0) begin
                write_reg(CFG_IDX_W'(CTL_IN_OFF),   {16'h0000, 16'h4000});
                write_reg(CFG_IDX_W'(CTL_OUT_OFF),  {16'h0100, 16'h1000});
                write_reg(CFG_IDX_W'(CTL_HI_GAIN),  {16'h0800, 16'h0400});
                write_reg(CFG_IDX_W'(CTL_TH_A),     {16'h0400, 16'h0000});
                write_reg(CFG_IDX_W'(CTL_MID_GAIN), {16'h0600, 16'h0000});
                write_reg(CFG_IDX_W'(CTL_TH_B),     {16'hF800, 16'h0000});
                write_reg(CFG_IDX_W'(CTL_LO_GAIN),  {16'hFE00, 16'h0000});
            end
            // High bits of the mode word must be dropped.
            write_reg(CFG_IDX_MODE, CFG_W'(32'hFFFF_FFF8 | m));
            end_cfg();
            push_sample(16'h1000, 16'h0000);
            push_sample(16'hE800, 16'h0000);
            if (m == 0) begin
                push_sample(16'h7FFF, 16'h7FFF);
                push_sample(16'h8000, 16'h8000);
                push_sample(16'h7FFF, 16'h8000);
            end
        end

        // Equal thresholds.
        wait_idle();
        write_reg(CFG_IDX_W'(CTL_TH_A), {16'h0200, 16'h0000});
        write_reg(CFG_IDX_W'(CTL_TH_B), {16'h0200, 16'h0000});
        write_reg(CFG_IDX_MODE, CFG_W'(CLAMP_OFF));
        end_cfg();
        push_sample(16'h0800, 16'h0000);
        push_sample(16'hF800, 16'h0000);
        push_sample(16'h0200, 16'h0000);

        // Threshold A below threshold B.
        wait_idle();
        write_reg(CFG_IDX_W'(CTL_TH_A), {16'hFC00, 16'h0000});
        write_reg(CFG_IDX_W'(CTL_TH_B), {16'h0800, 16'h0000});
        write_reg(CFG_IDX_MODE, CFG_W'({1'b1, CLAMP_BOTH}));
        end_cfg();
        push_sample(16'h0BB8, 16'h0000);
        push_sample(16'hF448, 16'h0000);

        // Spare index: no effect.
        wait_idle();
        write_reg(CFG_IDX_LAST, 32'h5A5A_A5A5);
        end_cfg();
        push_sample(16'h03E8, 16'h0000);

        for (ph = 0; ph < RND_PHASES; ph++) begin
            wait_idle();
            for (i = 0; i < N_CTL; i++) begin
                write_reg(CFG_IDX_W'(i), (ph == 0) ? 32'h7FFF_7FFF :
                                         (ph == 1) ? 32'h8000_8000 : pick_ctl_word());
            end
            write_reg(CFG_IDX_MODE, (ph == 0) ? CFG_W'({1'b1, CLAMP_BOTH}) :
                                    (ph == 1) ? CFG_W'(CLAMP_OFF) : CFG_W'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_MODE + 1, CFG_IDX_LAST)),
                          $urandom);
            end
            end_cfg();
            tx_idle_on = (ph != PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (ph == PRESSURE_PHASE) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                s.wave        = pick_cv();
                s.in_off_cv   = pick_cv();
                s.out_off_cv  = pick_cv();
                s.hi_gain_cv  = pick_cv();
                s.th_a_cv     = pick_cv();
                s.mid_gain_cv = pick_cv();
                s.th_b_cv     = pick_cv();
                s.lo_gain_cv  = pick_cv();
                sample_q = {sample_q, s};
            end
        end

        wait_idle();
        repeat (4 * N_STAGES) @(posedge clk);
        if (mismatches == 0 && shaped_wave_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tzw_pkg.sv
rtl/core/tzw_regs.sv
rtl/core/tzw_ctl.sv
rtl/core/tzw_shape.sv
rtl/core/tzw_out.sv
rtl/core/three_zone_window_waveshaper.sv
bench/three_zone_window_waveshaper_tb.sv
